>>> rtl/csrc_pkg.sv
// ----------------------------------------------------------------------------
// csrc_pkg
// Shared types and constants for the camera scaler ratio calculator.
// ----------------------------------------------------------------------------
package csrc_pkg;

  localparam int DIM_W            = 13;  // frame size fields
  localparam int STATUS_W         = 3;
  localparam int RATIO_W          = 6;   // prescale divisor, 1..32
  localparam int SHIFT_W          = 3;   // log2 of prescale divisor
  localparam int MAIN_W           = 9;   // main step, 8 fractional bits
  localparam int MAX_SHIFT        = 5;   // largest prescale shift
  localparam int RATIO_LIMIT_LOG2 = 6;   // ratio of 64 or more is an error
  localparam int LIMIT_W          = DIM_W + RATIO_LIMIT_LOG2;
  localparam int DIVISOR_W        = DIM_W + MAX_SHIFT;
  localparam int REM_W            = DIVISOR_W + 1;
  // edges from the accepting edge to the edge that raises done
  localparam int OUT_LATENCY      = MAIN_W + 1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_TARGET  = 3'd1,
    STATUS_BAD_SOURCE  = 3'd2,
    STATUS_HORIZ_LARGE = 3'd3,
    STATUS_VERT_LARGE  = 3'd4
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic [DIM_W-1:0] target_width;
    logic [DIM_W-1:0] target_height;
  } sizes_t;

  typedef struct packed {
    status_t            status;
    logic [RATIO_W-1:0] horiz_pre_ratio;
    logic [SHIFT_W-1:0] horiz_shift;
    logic [RATIO_W-1:0] vert_pre_ratio;
    logic [SHIFT_W-1:0] vert_shift;
    logic [DIM_W-1:0]   prescaled_width;
    logic [DIM_W-1:0]   prescaled_height;
    logic [MAIN_W-1:0]  main_horiz_ratio;
    logic [MAIN_W-1:0]  main_vert_ratio;
    logic               upscale_horiz;
    logic               upscale_vert;
  } result_t;

  // what one axis lane hands to the merge stage
  typedef struct packed {
    logic               tar_zero;
    logic               src_zero;
    logic               too_large;
    logic [RATIO_W-1:0] pre_ratio;
    logic [SHIFT_W-1:0] shift;
    logic [DIM_W-1:0]   prescaled;
    logic [MAIN_W-1:0]  main_ratio;
    logic               upscale;
  } lane_res_t;

endpackage

>>> rtl/csrc_lane.sv
// ----------------------------------------------------------------------------
// csrc_lane
// One axis: prescale pick, range checks and a pipelined main step divider.
// ----------------------------------------------------------------------------
module csrc_lane (
  input  logic                          clk,
  input  logic [csrc_pkg::DIM_W-1:0]    src,
  input  logic [csrc_pkg::DIM_W-1:0]    tar,
  output csrc_pkg::lane_res_t           res
);

  localparam int DIM_W     = csrc_pkg::DIM_W;
  localparam int MAIN_W    = csrc_pkg::MAIN_W;
  localparam int MAX_SHIFT = csrc_pkg::MAX_SHIFT;
  localparam int RL_LOG2   = csrc_pkg::RATIO_LIMIT_LOG2;
  localparam int DIVISOR_W = csrc_pkg::DIVISOR_W;
  localparam int REM_W     = csrc_pkg::REM_W;
  localparam int SHIFT_W   = csrc_pkg::SHIFT_W;
  localparam int RATIO_W   = csrc_pkg::RATIO_W;

  // setup stage logic
  logic [SHIFT_W-1:0]     shift;
  csrc_pkg::lane_res_t    setup;
  logic [DIVISOR_W-1:0]   divisor;

  always_comb begin
    shift = '0;
    // largest power of two with src >= tar * p wins
    for (int k = 1; k <= MAX_SHIFT; k++) begin
      if ({{MAX_SHIFT{1'b0}}, src} >= ({{MAX_SHIFT{1'b0}}, tar} << k)) begin
        shift = SHIFT_W'(k);
      end
    end
  end

  always_comb begin
    setup            = '0;
    setup.tar_zero   = (tar == '0);
    setup.src_zero   = (src == '0);
    setup.too_large  = {{RL_LOG2{1'b0}}, src} >= {tar, {RL_LOG2{1'b0}}};
    setup.pre_ratio  = RATIO_W'(1) << shift;
    setup.shift      = shift;
    setup.prescaled  = src >> shift;
    setup.upscale    = (tar >= src);
    divisor          = {{MAX_SHIFT{1'b0}}, tar} << shift;
  end

  // divider stages, one quotient bit each
  logic [REM_W-1:0]     rem_q  [0:MAIN_W-1];
  logic [DIVISOR_W-1:0] dvs_q  [0:MAIN_W-1];
  logic [MAIN_W-1:0]    quo_q  [0:MAIN_W];
  csrc_pkg::lane_res_t  meta_q [0:MAIN_W];

  always_ff @(posedge clk) begin
    rem_q[0]  <= {{(REM_W-DIM_W){1'b0}}, src};
    dvs_q[0]  <= divisor;
    quo_q[0]  <= '0;
    meta_q[0] <= setup;
  end

  for (genvar g = 1; g <= MAIN_W; g++) begin : g_div
    logic [REM_W-1:0] trial;
    logic             take;

    // first step gives the integer bit, later ones shift in fraction bits
    if (g == 1) begin : g_first
      assign trial = rem_q[g-1];
    end else begin : g_rest
      assign trial = {rem_q[g-1][REM_W-2:0], 1'b0};
    end

    assign take = (trial >= {1'b0, dvs_q[g-1]});

    always_ff @(posedge clk) begin
      quo_q[g]  <= quo_q[g-1] | (take ? (MAIN_W'(1) << (MAIN_W - g)) : '0);
      meta_q[g] <= meta_q[g-1];
    end

    if (g < MAIN_W) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[g] <= take ? (trial - {1'b0, dvs_q[g-1]}) : trial;
        dvs_q[g] <= dvs_q[g-1];
      end
    end
  end

  always_comb begin
    res            = meta_q[MAIN_W];
    res.main_ratio = quo_q[MAIN_W];
  end

endmodule

>>> rtl/csrc_merge.sv
// ----------------------------------------------------------------------------
// csrc_merge
// Combines both axis lanes into status and the registered result.
// ----------------------------------------------------------------------------
module csrc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  csrc_pkg::lane_res_t horiz,
  input  csrc_pkg::lane_res_t vert,
  output logic                done,
  output csrc_pkg::result_t   result
);

  csrc_pkg::status_t status;
  csrc_pkg::result_t result_next;

  always_comb begin
    if (horiz.tar_zero || vert.tar_zero) begin
      status = csrc_pkg::STATUS_BAD_TARGET;
    end else if (horiz.src_zero || vert.src_zero) begin
      status = csrc_pkg::STATUS_BAD_SOURCE;
    end else if (horiz.too_large) begin
      status = csrc_pkg::STATUS_HORIZ_LARGE;
    end else if (vert.too_large) begin
      status = csrc_pkg::STATUS_VERT_LARGE;
    end else begin
      status = csrc_pkg::STATUS_OK;
    end
  end

  always_comb begin
    result_next        = '0;
    result_next.status = status;
    if (status == csrc_pkg::STATUS_OK) begin
      result_next.horiz_pre_ratio  = horiz.pre_ratio;
      result_next.horiz_shift      = horiz.shift;
      result_next.vert_pre_ratio   = vert.pre_ratio;
      result_next.vert_shift       = vert.shift;
      result_next.prescaled_width  = horiz.prescaled;
      result_next.prescaled_height = vert.prescaled;
      result_next.main_horiz_ratio = horiz.main_ratio;
      result_next.main_vert_ratio  = vert.main_ratio;
      result_next.upscale_horiz    = horiz.upscale;
      result_next.upscale_vert     = vert.upscale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> rtl/camera_scaler_ratio_calc.sv
// ----------------------------------------------------------------------------
// camera_scaler_ratio_calc
// Scaler settings from source crop and target frame sizes, both axes at once.
// ----------------------------------------------------------------------------
//
//   channel   ports                 direction  transfer
//   --------  --------------------  ---------  ---------------------------
//   request   start, busy, sizes    in         start high, busy low
//   result    done, result          out        done high, one cycle only
//
// one transfer per cycle is taken; busy stays low, the pipeline never stalls
// done rises after the request passes the setup stage, nine divider stages of
// one quotient bit each and then the merge register; the result transfers at
// the edge after that
// the receiver cannot stall: done is a one-cycle strobe
// rst is synchronous; it clears the valid pipeline, requests in flight are lost
//
module camera_scaler_ratio_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  csrc_pkg::sizes_t   sizes,
  output logic               done,
  output csrc_pkg::result_t  result
);

  localparam int MAIN_W = csrc_pkg::MAIN_W;

  logic                accept;
  logic [MAIN_W:0]     vld;       // one valid bit per lane stage
  csrc_pkg::lane_res_t horiz_res;
  csrc_pkg::lane_res_t vert_res;

  // fully pipelined, so there is never a reason to hold requests off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[MAIN_W-1:0], accept};
    end
  end

  // horizontal lane
  csrc_lane u_lane_h (
    .clk (clk),
    .src (sizes.source_width),
    .tar (sizes.target_width),
    .res (horiz_res)
  );

  // vertical lane
  csrc_lane u_lane_v (
    .clk (clk),
    .src (sizes.source_height),
    .tar (sizes.target_height),
    .res (vert_res)
  );

  // status priority and zeroing on error, registered onto the result port
  csrc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[MAIN_W]),
    .horiz    (horiz_res),
    .vert     (vert_res),
    .done     (done),
    .result   (result)
  );

`ifndef SYNTH
  // every accepted transfer comes out after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(csrc_pkg::OUT_LATENCY + 1) done)
    else $error("result strobe missing after request");

  // an error result has zero prescale divisors, main ratios and upscale flags
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.status != csrc_pkg::STATUS_OK) |->
      (result.horiz_pre_ratio == '0 && result.vert_pre_ratio == '0 &&
       result.main_horiz_ratio == '0 && result.main_vert_ratio == '0 &&
       !result.upscale_horiz && !result.upscale_vert))
    else $error("error result has non-zero fields");

  // good results have power-of-two divisors matching their shifts
  a_ratio_shift : assert property (@(posedge clk) disable iff (rst)
    (done && result.status == csrc_pkg::STATUS_OK) |->
      ($onehot(result.horiz_pre_ratio) && $onehot(result.vert_pre_ratio) &&
       result.horiz_pre_ratio == (csrc_pkg::RATIO_W'(1) << result.horiz_shift) &&
       result.vert_pre_ratio == (csrc_pkg::RATIO_W'(1) << result.vert_shift)))
    else $error("prescale divisor and shift disagree");
`endif

endmodule
